/* rtl/msfb_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the motor speed frame builder.
// No dependencies; every other file imports this package.
package msfb_pkg;

   localparam int FRAME_BYTES = 10;
   localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 15;

   typedef logic [BYTE_IDX_W-1:0] byte_idx_type;

   localparam byte_idx_type OFS_ID      = BYTE_IDX_W'(0);
   localparam byte_idx_type OFS_CMD     = BYTE_IDX_W'(1);
   localparam byte_idx_type OFS_SPD_HI  = BYTE_IDX_W'(2);
   localparam byte_idx_type OFS_SPD_LO  = BYTE_IDX_W'(3);
   localparam byte_idx_type OFS_ACCEL   = BYTE_IDX_W'(6);
   localparam byte_idx_type OFS_BRAKE   = BYTE_IDX_W'(7);
   localparam byte_idx_type OFS_CRC     = BYTE_IDX_W'(FRAME_BYTES - 1);

   localparam logic [7:0] CRC_POLY = 8'h8C;

   localparam logic [7:0] INV_ID_A = 8'd1;
   localparam logic [7:0] INV_ID_B = 8'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_CODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_TIME   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_TIME   = 2'd3;

   localparam logic [7:0]  RST_COMMAND_CODE = 8'd100;
   localparam logic [14:0] RST_SPEED_LIMIT  = 15'd330;
   localparam logic [7:0]  RST_ACCEL_TIME   = 8'd10;
   localparam logic [7:0]  RST_BRAKE_TIME   = 8'd0;

   typedef struct packed {
      logic [7:0]         target_id;
      logic signed [15:0] speed_request;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  command_code;
      logic [14:0] speed_limit;
      logic [7:0]  accel_time;
      logic [7:0]  brake_time;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  target_id;
      logic [15:0] speed_word;
   } entry_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* rtl/msfb_front.sv */
// Front stage: takes request transfers, clamps and orients the speed, holds one entry.
// Depends on msfb_pkg.
module msfb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  msfb_pkg::req_type   req_payload,
   input  msfb_pkg::cfg_type   cfg,
   output logic                push_valid,
   output msfb_pkg::entry_type push_data,
   input  logic                push_stall
);
   import msfb_pkg::*;

   logic        hold_valid_ff, hold_valid_in;
   entry_type   hold_ff, hold_in;
   logic        accept;
   logic signed [16:0] spd_ext, lim_pos, lim_neg, clamped, oriented;
   logic        invert;

   assign req_stall = hold_valid_ff && push_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      spd_ext  = {req_payload.speed_request[15], req_payload.speed_request};
      lim_pos  = {2'b00, cfg.speed_limit};
      lim_neg  = -lim_pos;
      if (spd_ext > lim_pos) begin
         clamped = lim_pos;
      end else if (spd_ext < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = spd_ext;
      end
      invert   = (req_payload.target_id == INV_ID_A) ||
                 (req_payload.target_id == INV_ID_B);
      oriented = invert ? -clamped : clamped;
      hold_in.target_id  = req_payload.target_id;
      hold_in.speed_word = oriented[15:0];
      hold_valid_in      = accept || (hold_valid_ff && push_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      if (accept) begin
         hold_ff <= hold_in;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_data  = hold_ff;

endmodule

/* rtl/msfb_queue.sv */
// Short FIFO of frame entries between the front and back stages.
// Depends on msfb_pkg.
module msfb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  msfb_pkg::entry_type push_data,
   output logic                push_stall,
   input  logic                pop,
   output logic                pop_valid,
   output msfb_pkg::entry_type pop_data
);
   import msfb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_stall = (count_ff == CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/msfb_back.sv */
// Back stage: walks one entry through its frame, one byte per transfer, with running CRC-8.
// Depends on msfb_pkg.
module msfb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  msfb_pkg::entry_type pop_data,
   output logic                pop,
   input  msfb_pkg::cfg_type   cfg,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output msfb_pkg::rsp_type   rsp_payload
);
   import msfb_pkg::*;

   logic         active_ff, active_in;
   entry_type    entry_ff;
   byte_idx_type idx_ff, idx_in;
   logic [7:0]   crc_ff, crc_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   logic         out_free, load_en, at_end;
   logic [7:0]   cur_byte;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_en  = active_ff && out_free;
   assign at_end   = (idx_ff == OFS_CRC);
   assign pop      = pop_valid && (!active_ff || (load_en && at_end));

   always_comb begin
      case (idx_ff)
         OFS_ID:     cur_byte = entry_ff.target_id;
         OFS_CMD:    cur_byte = cfg.command_code;
         OFS_SPD_HI: cur_byte = entry_ff.speed_word[15:8];
         OFS_SPD_LO: cur_byte = entry_ff.speed_word[7:0];
         OFS_ACCEL:  cur_byte = cfg.accel_time;
         OFS_BRAKE:  cur_byte = cfg.brake_time;
         OFS_CRC:    cur_byte = crc_ff;
         default:    cur_byte = 8'h00;
      endcase

      active_in    = active_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;

      if (load_en) begin
         rsp_in.frame_byte = cur_byte;
         rsp_in.last       = at_end;
         rsp_valid_in      = 1'b1;
         crc_in            = crc8_update(crc_ff, cur_byte);
         idx_in            = idx_ff + 1'b1;
         if (at_end) begin
            active_in = 1'b0;
         end
      end
      if (pop) begin
         active_in = 1'b1;
         idx_in    = '0;
         crc_in    = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      crc_ff <= crc_in;
      rsp_ff <= rsp_in;
      if (pop) begin
         entry_ff <= pop_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff <= OFS_CRC))
      else $error("byte index past end of frame");

   a_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !(load_en && at_end)) |-> !pop)
      else $error("entry taken while a frame is in progress");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (load_en && at_end) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("closing byte not flagged last");

   a_gap_after_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last && !rsp_stall && !active_ff) |=> !rsp_valid_ff)
      else $error("byte presented without an active frame");

endmodule

/* rtl/motor_speed_frame_builder.sv */
// Motor speed frame builder. Each request transfer (motor id, signed speed) yields ten
// response transfers: id, command code, big-endian clamped speed (negated for ids 1 and 3),
// two zero bytes, acceleration time, brake time, a zero byte and a reflected CRC-8
// (polynomial 0x8C, initial 0) flagged last. Bytes go out one per cycle while the response
// side does not stall; frames then leave back to back and the next request is taken while
// the current frame is still going out, up to QUEUE_DEPTH frames plus one held in the front
// stage. The user must write configuration registers through the csr port only while no
// frame is pending, which the block does not enforce; both stages read them live.
module motor_speed_frame_builder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  msfb_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output msfb_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_wr_en,
   input  logic [msfb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [msfb_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import msfb_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_stall;
   entry_type push_data, pop_data;
   logic      pop, pop_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COMMAND_CODE: cfg_in.command_code = csr_wdata[7:0];
            CSR_SPEED_LIMIT:  cfg_in.speed_limit  = csr_wdata[14:0];
            CSR_ACCEL_TIME:   cfg_in.accel_time   = csr_wdata[7:0];
            CSR_BRAKE_TIME:   cfg_in.brake_time   = csr_wdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_code <= RST_COMMAND_CODE;
         cfg_ff.speed_limit  <= RST_SPEED_LIMIT;
         cfg_ff.accel_time   <= RST_ACCEL_TIME;
         cfg_ff.brake_time   <= RST_BRAKE_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .push_stall  (push_stall)
   );

   msfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_stall (push_stall),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   msfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_data    (pop_data),
      .pop         (pop),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* sim/msfb_checker.sv */
// Scoreboard for the motor speed frame builder: tracks register writes, predicts the ten-byte
// frame of every request transfer and compares each response transfer in order.
// Depends on msfb_pkg for the payload types, register indexes and reset values.
module msfb_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  msfb_pkg::req_type                  req_payload,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  msfb_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_wr_en,
   input  logic [msfb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [msfb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                 error_count,
   output int                                 pending_bytes
);
   import msfb_pkg::*;

   logic [7:0]  cmd_code_q;
   logic [14:0] speed_limit_q;
   logic [7:0]  accel_q;
   logic [7:0]  brake_q;
   rsp_type     frame_bytes_due[$];

   initial begin
      error_count = 0;
   end

   assign pending_bytes = frame_bytes_due.size();

   task automatic queue_frame(input req_type r);
      logic [7:0] frame[FRAME_BYTES];
      logic [7:0] crc;
      logic [15:0] word;
      rsp_type    b;
      int         spd;
      int         lim;
      spd = int'($signed(r.speed_request));
      lim = int'(speed_limit_q);
      if (spd > lim) spd = lim;
      if (spd < -lim) spd = -lim;
      if (r.target_id == INV_ID_A || r.target_id == INV_ID_B) spd = -spd;
      word = spd[15:0];
      frame[0] = r.target_id;
      frame[1] = cmd_code_q;
      frame[2] = word[15:8];
      frame[3] = word[7:0];
      frame[4] = 8'h00;
      frame[5] = 8'h00;
      frame[6] = accel_q;
      frame[7] = brake_q;
      frame[8] = 8'h00;
      crc = 8'h00;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         crc = crc ^ frame[i];
         for (int j = 0; j < 8; j++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
         end
      end
      frame[FRAME_BYTES - 1] = crc;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         b.frame_byte = frame[k];
         b.last       = (k == FRAME_BYTES - 1);
         frame_bytes_due.push_back(b);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cmd_code_q    <= RST_COMMAND_CODE;
         speed_limit_q <= RST_SPEED_LIMIT;
         accel_q       <= RST_ACCEL_TIME;
         brake_q       <= RST_BRAKE_TIME;
         frame_bytes_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COMMAND_CODE: cmd_code_q    <= csr_wdata[7:0];
               CSR_SPEED_LIMIT:  speed_limit_q <= csr_wdata[14:0];
               CSR_ACCEL_TIME:   accel_q       <= csr_wdata[7:0];
               CSR_BRAKE_TIME:   brake_q       <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_bytes_due.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected rsp transfer byte %02h last %0b",
                           $realtime, rsp_payload.frame_byte, rsp_payload.last);
               error_count++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (want.frame_byte !== rsp_payload.frame_byte ||
                   want.last !== rsp_payload.last) begin
                  if (error_count < 10)
                     $display("%0t: rsp mismatch expected byte %02h last %0b, got %02h last %0b",
                              $realtime, want.frame_byte, want.last,
                              rsp_payload.frame_byte, rsp_payload.last);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) queue_frame(req_payload);
      end
   end

endmodule

/* sim/tb_top.sv */
// Top of the motor speed frame builder testbench: clock, reset, request and register stimulus,
// response stalls and the verdict. Depends on msfb_pkg, the block and msfb_checker.
module tb_top;
   import msfb_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_payload;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    error_count;
   int                    pending_bytes;
   int                    send_idle_pct;
   int                    stall_pct;
   bit                    hold_rsp;
   int                    cur_limit;

   motor_speed_frame_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   msfb_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_bytes (pending_bytes)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #3_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // hold off the response side for a long stretch when asked, else stall at random
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   task automatic offer_request(input logic [7:0] id, input logic signed [15:0] spd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid                 = 1'b1;
      req_payload.target_id     = id;
      req_payload.speed_request = spd;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic load_config(input logic [7:0] cmd, input logic [14:0] lim,
                              input logic [7:0] acc, input logic [7:0] brk);
      req_valid = 1'b0;
      while (pending_bytes != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      write_reg(CSR_COMMAND_CODE, {7'($urandom), cmd});
      write_reg(CSR_SPEED_LIMIT, lim);
      write_reg(CSR_ACCEL_TIME, {7'($urandom), acc});
      write_reg(CSR_BRAKE_TIME, {7'($urandom), brk});
      cur_limit = int'(lim);
   endtask

   function automatic logic [14:0] random_limit();
      return ($urandom_range(3) == 0) ? 15'($urandom_range(32767)) : 15'($urandom_range(600));
   endfunction

   function automatic logic signed [15:0] random_speed(input int lim);
      case ($urandom_range(7))
         0, 1:    return 16'($urandom);
         2:       return 16'(lim);
         3:       return 16'(-lim);
         4:       return 16'(lim + 1);
         5:       return 16'(-lim - 1);
         default: return 16'(int'($urandom_range(2 * lim + 4)) - lim - 2);
      endcase
   endfunction

   task automatic random_batch(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (count) begin
         offer_request($urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom),
                       random_speed(cur_limit));
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_rsp      = 1'b0;
      cur_limit     = int'(RST_SPEED_LIMIT);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      offer_request(8'd0, 16'sd0);
      offer_request(8'd1, 16'sd330);
      offer_request(8'd3, -16'sd330);
      offer_request(8'd2, 16'sd331);
      offer_request(8'd0, -16'sd331);
      offer_request(8'd1, 16'sd32767);
      offer_request(8'd3, -16'sd32768);
      offer_request(8'd255, 16'sd1);
      offer_request(8'd254, -16'sd1);
      offer_request(8'd1, 16'sd100);
      offer_request(8'd3, -16'sd200);
      offer_request(8'd4, 16'sd329);
      offer_request(8'd128, -16'sd32768);
      offer_request(8'd127, 16'sd32767);

      load_config(8'd255, 15'd32767, 8'd0, 8'd0);
      offer_request(8'd1, -16'sd32768);
      offer_request(8'd3, 16'sd32767);
      offer_request(8'd0, -16'sd32768);
      offer_request(8'd2, 16'sd32767);
      offer_request(8'd255, -16'sd1);
      random_batch(55, 0, 0);

      load_config(8'd0, 15'd0, 8'd255, 8'd255);
      offer_request(8'd1, -16'sd32768);
      offer_request(8'd0, 16'sd32767);
      offer_request(8'd3, 16'sd5);
      random_batch(55, 83, 0);

      load_config(8'($urandom), random_limit(), 8'($urandom), 8'($urandom));
      random_batch(55, 0, 83);

      load_config(8'($urandom), 15'd1, 8'($urandom), 8'($urandom));
      random_batch(55, 9, 9);

      load_config(8'($urandom), random_limit(), 8'($urandom), 8'($urandom));
      hold_rsp = 1'b1;
      random_batch(60, 0, 0);

      load_config(RST_COMMAND_CODE, RST_SPEED_LIMIT, RST_ACCEL_TIME, RST_BRAKE_TIME);
      random_batch(55, 20, 20);

      req_valid = 1'b0;
      while (pending_bytes != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (error_count == 0 && pending_bytes == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
